>>> hw/rtl/iee_pkg.sv
// shared types and constants of the infix expression evaluator
package iee_pkg;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // token kinds passed from front to back
  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_MUL,
    TK_DIV,
    TK_ADD,
    TK_SUB,
    TK_EQ
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
  } token_t;

  // pending multiplicative operation
  typedef enum logic [1:0] {
    OP_NONE,
    OP_MUL,
    OP_DIV
  } term_op_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ITER,
    BK_FINISH
  } bk_state_t;

  // multiply / divide unit states
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_RUN,
    MD_DONE
  } md_state_t;

  // request into the multiply / divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  // status out of the multiply / divide unit
  typedef struct packed {
    logic done;
    logic div0;
  } md_stat_t;

endpackage

>>> hw/rtl/iee_front.sv
// front end: accepts characters and turns them into tokens
module iee_front (
  input  logic            in_valid,
  input  logic [7:0]      in_char_code,
  output logic            in_stall,
  input  logic            fifo_full,
  output logic            push,
  output iee_pkg::token_t push_tok
);
  import iee_pkg::*;

  logic accept;
  logic is_digit;

  // a word is taken whenever the token queue has room
  assign in_stall = fifo_full;
  assign accept   = in_valid && !fifo_full;
  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);

  // classify the character, spaces and unknown codes are dropped
  always_comb begin
    push           = 1'b0;
    push_tok.kind  = TK_DIGIT;
    push_tok.digit = 4'(in_char_code - CH_ZERO);
    case (in_char_code)
      CH_STAR: begin
        push          = accept;
        push_tok.kind = TK_MUL;
      end
      CH_SLASH: begin
        push          = accept;
        push_tok.kind = TK_DIV;
      end
      CH_PLUS: begin
        push          = accept;
        push_tok.kind = TK_ADD;
      end
      CH_MINUS: begin
        push          = accept;
        push_tok.kind = TK_SUB;
      end
      CH_EQUAL: begin
        push          = accept;
        push_tok.kind = TK_EQ;
      end
      CH_SPACE: begin
        push = 1'b0;
      end
      default: begin
        push = accept && is_digit;
      end
    endcase
  end

endmodule

>>> hw/rtl/iee_fifo.sv
// short token queue between front and back, depth a power of two
module iee_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  iee_pkg::token_t wdata,
  input  logic            pop,
  output iee_pkg::token_t rdata,
  output logic            full,
  output logic            empty
);
  import iee_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  token_t        mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> hw/rtl/iee_muldiv.sv
// shared bit-serial multiply and signed divide unit, one bit per cycle
module iee_muldiv #(
  parameter int W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  iee_pkg::md_ctrl_t ctrl,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output iee_pkg::md_stat_t stat,
  output logic [W-1:0]      result
);
  import iee_pkg::*;

  localparam int CW = $clog2(W + 1);

  md_state_t     state_r, state_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          div_r, div_nxt;
  logic          neg_r, neg_nxt;
  logic          div0_r, div0_nxt;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MD_IDLE: begin
        if (ctrl.start) begin
          state_nxt = (ctrl.is_div && (b == '0)) ? MD_DONE : MD_RUN;
        end
      end
      MD_RUN: begin
        if (cnt_r == CW'(1)) begin
          state_nxt = MD_DONE;
        end
      end
      MD_DONE: begin
        state_nxt = MD_IDLE;
      end
      default: begin
        state_nxt = MD_IDLE;
      end
    endcase
  end

  // restoring divide step
  assign shifted = {acc_r, a_r[W-1]};
  assign trial   = shifted - {1'b0, b_r};

  // datapath
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    div0_nxt = div0_r;
    case (state_r)
      MD_IDLE: begin
        if (ctrl.start) begin
          div_nxt = ctrl.is_div;
          acc_nxt = '0;
          cnt_nxt = CW'(W);
          if (ctrl.is_div) begin
            a_nxt    = a[W-1] ? -a : a;
            b_nxt    = b[W-1] ? -b : b;
            neg_nxt  = a[W-1] ^ b[W-1];
            div0_nxt = (b == '0);
            if (b == '0) begin
              a_nxt   = '0;
              neg_nxt = 1'b0;
            end
          end else begin
            a_nxt    = a;
            b_nxt    = b;
            neg_nxt  = 1'b0;
            div0_nxt = 1'b0;
          end
        end
      end
      MD_RUN: begin
        cnt_nxt = cnt_r - CW'(1);
        if (div_r) begin
          if (!trial[W]) begin
            acc_nxt = trial[W-1:0];
            a_nxt   = {a_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = shifted[W-1:0];
            a_nxt   = {a_r[W-2:0], 1'b0};
          end
        end else begin
          if (a_r[0]) begin
            acc_nxt = acc_r + b_r;
          end
          a_nxt = a_r >> 1;
          b_nxt = b_r << 1;
        end
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  // outputs
  always_comb begin
    stat.done = (state_r == MD_DONE);
    stat.div0 = div_r && div0_r;
    if (div_r) begin
      result = neg_r ? -a_r : a_r;
    end else begin
      result = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    cnt_r  <= cnt_nxt;
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
    div0_r <= div0_nxt;
  end

endmodule

>>> hw/rtl/iee_back.sv
// back end: executes tokens, holds the expression state and the result register
module iee_back #(
  parameter int W = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  iee_pkg::token_t head_tok,
  input  logic            fifo_empty,
  output logic            fifo_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     out_value,
  output logic            out_status
);
  import iee_pkg::*;

  bk_state_t    state_r, state_nxt;
  logic [W-1:0] cur_r, cur_nxt;
  logic [W-1:0] term_r, term_nxt;
  term_op_t     op_r, op_nxt;
  logic [W-1:0] sum_r, sum_nxt;
  logic         sign_r, sign_nxt;
  logic         err_r, err_nxt;
  tok_kind_t    tok_r, tok_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  out_value_r, out_value_nxt;
  logic         out_status_r, out_status_nxt;

  md_ctrl_t     md_ctrl;
  md_stat_t     md_stat;
  logic [W-1:0] md_result;
  logic         have_tok;
  logic         is_op_tok;
  logic         out_free;
  logic         finish_go;
  logic [W-1:0] closed_sum;

  assign have_tok  = !fifo_empty;
  assign is_op_tok = (head_tok.kind != TK_DIGIT);
  assign out_free  = !out_valid_r || !out_stall;
  assign finish_go = (tok_r != TK_EQ) || out_free;
  assign closed_sum = sign_r ? sum_r - term_r : sum_r + term_r;

  iee_muldiv #(.W(W)) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (md_ctrl),
    .a      (term_r),
    .b      (cur_r),
    .stat   (md_stat),
    .result (md_result)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (have_tok && is_op_tok) begin
          state_nxt = (op_r == OP_NONE) ? BK_FINISH : BK_ITER;
        end
      end
      BK_ITER: begin
        if (md_stat.done) begin
          state_nxt = BK_FINISH;
        end
      end
      BK_FINISH: begin
        if (finish_go) begin
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // datapath and control outputs
  always_comb begin
    cur_nxt        = cur_r;
    term_nxt       = term_r;
    op_nxt         = op_r;
    sum_nxt        = sum_r;
    sign_nxt       = sign_r;
    err_nxt        = err_r;
    tok_nxt        = tok_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    fifo_pop       = 1'b0;
    md_ctrl.start  = 1'b0;
    md_ctrl.is_div = (op_r == OP_DIV);
    case (state_r)
      BK_IDLE: begin
        if (have_tok) begin
          fifo_pop = 1'b1;
          if (!is_op_tok) begin
            // decimal digit: cur * 10 + d
            cur_nxt = (cur_r << 3) + (cur_r << 1) + W'(head_tok.digit);
          end else begin
            tok_nxt = head_tok.kind;
            if (op_r == OP_NONE) begin
              term_nxt = cur_r;
            end else begin
              md_ctrl.start = 1'b1;
            end
          end
        end
      end
      BK_ITER: begin
        if (md_stat.done) begin
          term_nxt = md_result;
          err_nxt  = err_r || md_stat.div0;
        end
      end
      BK_FINISH: begin
        cur_nxt = '0;
        case (tok_r)
          TK_MUL: begin
            op_nxt = OP_MUL;
          end
          TK_DIV: begin
            op_nxt = OP_DIV;
          end
          TK_ADD, TK_SUB: begin
            sum_nxt  = closed_sum;
            term_nxt = '0;
            op_nxt   = OP_NONE;
            sign_nxt = (tok_r == TK_SUB);
          end
          TK_EQ: begin
            if (out_free) begin
              out_valid_nxt  = 1'b1;
              out_value_nxt  = 32'($signed(closed_sum));
              out_status_nxt = err_r;
              term_nxt       = '0;
              op_nxt         = OP_NONE;
              sum_nxt        = '0;
              sign_nxt       = 1'b0;
              err_nxt        = 1'b0;
            end
          end
          default: begin
            op_nxt = op_r;
          end
        endcase
      end
      default: begin
        fifo_pop = 1'b0;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cur_r       <= '0;
      term_r      <= '0;
      op_r        <= OP_NONE;
      sum_r       <= '0;
      sign_r      <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      term_r      <= term_nxt;
      op_r        <= op_nxt;
      sum_r       <= sum_nxt;
      sign_r      <= sign_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r        <= tok_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  // the iterative unit only runs for a pending multiply or divide
  a_iter_has_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_ITER) |-> (op_r != OP_NONE))
    else $error("iteration without a pending operation");

  // the iterative unit reports done only while the sequencer waits for it
  a_done_in_iter: assert property (@(posedge clk) disable iff (!rst_n)
    md_stat.done |-> (state_r == BK_ITER))
    else $error("unexpected done from multiply/divide unit");

  // tokens leave the queue only between operations
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> (state_r == BK_IDLE && !fifo_empty))
    else $error("token popped while busy");

  // a finished expression loads the result and clears the running state
  a_eq_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FINISH && tok_r == TK_EQ && out_free)
      |=> (out_valid_r && sum_r == '0 && err_r == 1'b0 && op_r == OP_NONE))
    else $error("expression end did not publish and clear");

endmodule

>>> hw/rtl/infix_expression_evaluator_core.sv
// top level of the infix expression evaluator
//
// Input channel: one ASCII character per word on in_char_code, taken on a
// clock edge where in_valid is high and in_stall is low. Digits build a
// decimal operand, '*' and '/' fold into a term, '+' and '-' close a term
// into the sum, and '=' ends the expression. Spaces and other codes vanish.
// Output channel: one word per '=', out_value (signed 32 bits, wrapped) and
// out_status (1 when a division by zero happened in that expression).
// Flow: the front end classifies a character in the
// cycle it arrives and writes it into a four-entry token queue. The back end
// pops a digit straight from its idle state and passes an operator with no
// pending '*' or '/' through its finish state. An operator that closes a
// multiply or divide runs the bit-serial multiply/divide unit, one bit a
// cycle; a division by zero skips the iterations. A '=' loads the output
// register from the finish state once that register is free, as
// its term closes. When out_stall holds, the result register keeps its word,
// the back end waits at the next '=' and the queue fills until in_stall
// rises. Reset clears the expression state, the queue and the output valid.
module infix_expression_evaluator_core #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_char_code,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_value,
  output logic        out_status
);
  import iee_pkg::*;

  logic   push;
  token_t push_tok;
  logic   pop;
  token_t head_tok;
  logic   fifo_full;
  logic   fifo_empty;

  // character classification
  iee_front u_front (
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_stall     (in_stall),
    .fifo_full    (fifo_full),
    .push         (push),
    .push_tok     (push_tok)
  );

  // token queue
  iee_fifo #(.DEPTH(4)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_tok),
    .pop   (pop),
    .rdata (head_tok),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  // evaluation
  iee_back #(.W(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_tok   (head_tok),
    .fifo_empty (fifo_empty),
    .fifo_pop   (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// testbench of the infix expression evaluator: directed table, random expressions, predictor
module tb_top;
  import iee_pkg::*;

  localparam int RANDOM_ITEMS = 1750;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [31:0] value;
    logic        status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_char_code = 8'h00;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value;
  logic        out_status;

  infix_expression_evaluator_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_char_code(in_char_code),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_value   (out_value),
    .out_status  (out_status)
  );

  // clock
  initial begin
    forever #10 clk = ~clk;
  end

  // expression state of the predictor
  logic [31:0] operand_acc = '0;
  logic [31:0] term_acc = '0;
  term_op_t    term_op = OP_NONE;
  logic [31:0] sum_acc = '0;
  logic        subtract_next = 1'b0;
  logic        div_zero_seen = 1'b0;

  result_t pending_results[$];

  int  error_count = 0;
  int  results_checked = 0;
  int  div0_results = 0;
  int  cycle_count = 0;
  bit  calm = 1'b0;
  bit  squeeze_req = 1'b0;
  bit  squeeze_done = 1'b0;

  // directed table: '#' stands for code 0x00 and '~' for 0xff
  string       row_text   [4] = '{"# -~=", "7/0=", "8/*3+=", "2147483648/4294967295="};
  bit          row_typed  [4] = '{1'b1, 1'b1, 1'b0, 1'b1};
  logic [31:0] row_value  [4] = '{32'd0, 32'd0, 32'd0, 32'h8000_0000};
  logic        row_status [4] = '{1'b0, 1'b1, 1'b0, 1'b0};

  logic [31:0] notable_operands [5] =
    '{32'd2147483647, 32'd2147483648, 32'hFFFF_FFFF, 32'd65536, 32'd46341};
  logic [7:0]  op_codes [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

  // signed division truncated toward zero, wrapping at 32 bits
  function automatic logic [31:0] quotient_toward_zero(input logic [31:0] a,
                                                       input logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (mb == '0) return '0;
    q = ma / mb;
    return (a[31] ^ b[31]) ? -q : q;
  endfunction

  // fold the finished operand into the running term
  function automatic void fold_operand();
    case (term_op)
      OP_MUL: term_acc = term_acc * operand_acc;
      OP_DIV: begin
        if (operand_acc == '0) div_zero_seen = 1'b1;
        term_acc = quotient_toward_zero(term_acc, operand_acc);
      end
      default: term_acc = operand_acc;
    endcase
    operand_acc = '0;
  endfunction

  // add or subtract the finished term into the sum
  function automatic void close_term();
    sum_acc  = subtract_next ? sum_acc - term_acc : sum_acc + term_acc;
    term_acc = '0;
    term_op  = OP_NONE;
  endfunction

  // advance the expression by one character, return 1 when a result is due
  function automatic bit evaluate_char(input logic [7:0] code, output result_t res);
    res = '0;
    if (code >= CH_ZERO && code <= CH_NINE) begin
      operand_acc = operand_acc * 32'd10 + {28'd0, code[3:0]};
      return 1'b0;
    end
    case (code)
      CH_STAR, CH_SLASH: begin
        fold_operand();
        term_op = (code == CH_STAR) ? OP_MUL : OP_DIV;
      end
      CH_PLUS, CH_MINUS: begin
        fold_operand();
        close_term();
        subtract_next = (code == CH_MINUS);
      end
      CH_EQUAL: begin
        fold_operand();
        close_term();
        res.value     = sum_acc;
        res.status    = div_zero_seen;
        operand_acc   = '0;
        term_acc      = '0;
        term_op       = OP_NONE;
        sum_acc       = '0;
        subtract_next = 1'b0;
        div_zero_seen = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // offer one character word, wait for it to be taken, then predict
  task automatic send_char(input logic [7:0] code, input bit typed,
                           input logic [31:0] typed_value, input logic typed_status);
    result_t res;
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= code;
    do @(posedge clk); while (in_stall);
    if (evaluate_char(code, res)) begin
      if (typed) begin
        res.value  = typed_value;
        res.status = typed_status;
      end
      pending_results.push_back(res);
    end
  endtask

  // result side: check taken words, then pick the next stall
  initial begin : result_sink
    int      hold_left;
    result_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: value %0d status %0b",
                   $time, $signed(out_value), out_status);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_value !== want.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d",
                     $time, $signed(want.value), $signed(out_value));
            error_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0b, actual %0b",
                     $time, want.status, out_status);
            error_count++;
          end
          results_checked++;
          if (want.status) div0_results++;
        end
      end
      // one long hold-off so the block backs up into its input
      if (squeeze_req && !squeeze_done) begin
        hold_left    = HOLD_CYCLES;
        squeeze_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 22);
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [7:0] ch;
    logic [7:0] expr_chars[$];
    string      operand;
    int         n_operands;
    int         n_digits;
    int         pick;
    int         random_items;
    int         expressions;
    random_items = 0;
    expressions  = 0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (row_text[r]) begin
      for (int i = 0; i < row_text[r].len(); i++) begin
        ch = row_text[r][i];
        if (ch == "#") ch = 8'h00;
        else if (ch == "~") ch = 8'hFF;
        send_char(ch, row_typed[r], row_value[r], row_status[r]);
      end
      expressions++;
    end

    // random expressions: mostly well formed, some noise and missing operands
    while (random_items < RANDOM_ITEMS) begin
      expr_chars.delete();
      n_operands = $urandom_range(1, 5);
      for (int k = 0; k < n_operands; k++) begin
        if ($urandom_range(0, 9) == 0) expr_chars.push_back(CH_SPACE);
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          // missing operand
        end else if (pick < 18) begin
          expr_chars.push_back(CH_ZERO);
        end else if (pick < 28) begin
          operand = $sformatf("%0d", notable_operands[$urandom_range(0, 4)]);
          for (int j = 0; j < operand.len(); j++) expr_chars.push_back(operand[j]);
        end else begin
          // long operands wrap while they build up
          n_digits = (pick < 36) ? $urandom_range(10, 12) : $urandom_range(1, 3);
          repeat (n_digits) expr_chars.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) == 0) expr_chars.push_back(CH_SPACE);
        if ($urandom_range(0, 12) == 0) expr_chars.push_back(8'($urandom_range(0, 255)));
        if (k < n_operands - 1) begin
          expr_chars.push_back(op_codes[$urandom_range(0, 3)]);
          if ($urandom_range(0, 19) == 0) expr_chars.push_back(op_codes[$urandom_range(0, 3)]);
        end
      end
      expr_chars.push_back(CH_EQUAL);

      foreach (expr_chars[j]) begin
        send_char(expr_chars[j], 1'b0, '0, 1'b0);
        if (expr_chars[j] inside {[CH_ZERO:CH_NINE], CH_PLUS, CH_MINUS, CH_STAR,
                                  CH_SLASH, CH_EQUAL})
          random_items++;
        calm = (random_items >= 900 && random_items < 1200);
        if (random_items >= 400) squeeze_req = 1'b1;
      end
      expressions++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // drain
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d expressions (%0d scored random characters), checked %0d results",
             expressions, random_items, results_checked);
    $display("%0d results flagged a division by zero, %0d errors", div0_results, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
